// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset masks the check
`define DWT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, reset masks the check
`define DWT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hw/rtl/dwt_pkg.sv =====
// shared constants, codes and control types of the deadline watch table
// no dependencies
`timescale 1ns / 1ps

package dwt_pkg;

	// table geometry
	localparam int SLOTS        = 16;
	localparam int TASK_ID_BITS = 16;
	localparam int TIME_BITS    = 32;
	localparam int IDX_W        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W        = $clog2(SLOTS + 1);

	// port field widths
	localparam int OP_W    = 3;
	localparam int TASK_W  = 16;
	localparam int LIMIT_W = 32;
	localparam int SIDX_W  = 4;
	localparam int NOW_W   = 32;
	localparam int MASK_W  = 16;
	localparam int KIND_W  = 2;
	localparam int LCNT_W  = 5;

	// operation codes
	localparam logic [OP_W-1:0] OP_WATCH      = 3'd0;
	localparam logic [OP_W-1:0] OP_LOOKUP     = 3'd1;
	localparam logic [OP_W-1:0] OP_REMOVE     = 3'd2;
	localparam logic [OP_W-1:0] OP_RESTART    = 3'd3;
	localparam logic [OP_W-1:0] OP_SCAN       = 3'd4;
	localparam logic [OP_W-1:0] OP_SCAN_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_CLEAR      = 3'd6;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_ACK     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_VIOL    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd2;

	// start point of the slot walk
	localparam logic [1:0] IDX_ZERO = 2'd0;
	localparam logic [1:0] IDX_TOP  = 2'd1;
	localparam logic [1:0] IDX_ITEM = 2'd2;

	// source of the reported slot
	localparam logic [1:0] SSEL_ZERO = 2'd0;
	localparam logic [1:0] SSEL_IDX  = 2'd1;
	localparam logic [1:0] SSEL_ITEM = 2'd2;

	// source of the reported task
	localparam logic [1:0] TSEL_ZERO = 2'd0;
	localparam logic [1:0] TSEL_ITEM = 2'd1;
	localparam logic [1:0] TSEL_SLOT = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic              load;
		logic [1:0]        idx_init;
		logic              step_up;
		logic              step_down;
		logic              claim;
		logic              restart;
		logic              free;
		logic              clear_all;
		logic              emit;
		logic [KIND_W-1:0] kind;
		logic              ok;
		logic [1:0]        slot_sel;
		logic [1:0]        task_sel;
		logic              last;
	} dwt_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
		logic cur_valid;
		logic task_match;
		logic done_bit;
		logic overdue;
		logic at_top;
		logic at_zero;
		logic rm_in_range;
	} dwt_status_t;

endpackage

// ===== hw/rtl/dwt_if.sv =====
// item and result channel interfaces of the deadline watch table
// depends on dwt_pkg
`timescale 1ns / 1ps

interface dwt_in_if;
	import dwt_pkg::*;

	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    op;
	logic [TASK_W-1:0]  task_id;
	logic [LIMIT_W-1:0] limit;
	logic [SIDX_W-1:0]  slot_index;
	logic [NOW_W-1:0]   now;
	logic [MASK_W-1:0]  done_mask;

	modport source (
		output valid, op, task_id, limit, slot_index, now, done_mask,
		input  ready
	);
	modport sink (
		input  valid, op, task_id, limit, slot_index, now, done_mask,
		output ready
	);
endinterface

interface dwt_out_if;
	import dwt_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic              ok;
	logic [SIDX_W-1:0] slot_index_out;
	logic [TASK_W-1:0] task_id_out;
	logic [LCNT_W-1:0] live_count_out;
	logic              last;

	modport source (
		output valid, kind, ok, slot_index_out, task_id_out, live_count_out, last,
		input  ready
	);
	modport sink (
		input  valid, kind, ok, slot_index_out, task_id_out, live_count_out, last,
		output ready
	);
endinterface

// ===== hw/rtl/deadline_watch_table_unit.sv =====
// top level of the deadline watch table: controller plus datapath
// depends on dwt_pkg, dwt_if, dwt_ctrl and dwt_datapath
`timescale 1ns / 1ps

// Deadline watch table of SLOTS (16) slots, each holding a task id, a limit and a
// start time. One item is worked on at a time; the walk index reads one slot per
// cycle through its single slot read port, except while the result side stalls.
// Remove, clear and unused codes need no walk; watch searches downward from
// the top slot; lookup and restart search upward from slot zero; scan and
// scan-first walk upward from slot zero. The walk stands still in every cycle
// in which the result register holds a result that is not being transferred.
// A new item is taken as soon as the final result of the previous one is
// registered, even while that result waits for transfer.
// live_count_out reports the occupied slots after the step that made the result.

module deadline_watch_table_unit (
	input  logic       clk,
	input  logic       arst_n,
	dwt_in_if.sink     item,
	dwt_out_if.source  result
);
	import dwt_pkg::*;

	dwt_cmd_t    cmd;
	dwt_status_t st;

	dwt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_op    (item.op),
		.in_ready (item.ready),
		.st       (st),
		.cmd      (cmd)
	);

	dwt_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.in_task_id     (item.task_id),
		.in_limit       (item.limit),
		.in_slot_index  (item.slot_index),
		.in_now         (item.now),
		.in_done_mask   (item.done_mask),
		.out_ready      (result.ready),
		.out_valid      (result.valid),
		.out_kind       (result.kind),
		.out_ok         (result.ok),
		.out_slot_index (result.slot_index_out),
		.out_task_id    (result.task_id_out),
		.out_live_count (result.live_count_out),
		.out_last       (result.last)
	);

endmodule

// ===== hw/rtl/dwt_ctrl.sv =====
// controller of the deadline watch table: decodes the operation and steers
// the slot walk one slot per cycle while the result side does not stall; depends on dwt_pkg
`timescale 1ns / 1ps

module dwt_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic [dwt_pkg::OP_W-1:0] in_op,
	output logic                     in_ready,
	input  dwt_pkg::dwt_status_t     st,
	output dwt_pkg::dwt_cmd_t        cmd
);
	import dwt_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_SUM  = 2'd2;

	logic [1:0]      state_q, state_d;
	logic [OP_W-1:0] op_q, op_d;
	logic            clean_q, clean_d;

	assign in_ready = (state_q == ST_IDLE);

	// state and operation registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_WATCH;
			clean_q <= 1'b1;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			clean_q <= clean_d;
		end
	end

	// next state and datapath commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		op_d    = op_q;
		clean_d = clean_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					op_d     = in_op;
					clean_d  = 1'b1;
					state_d  = ST_RUN;
					case (in_op)
						OP_WATCH:  cmd.idx_init = IDX_TOP;
						OP_REMOVE: cmd.idx_init = IDX_ITEM;
						default:   cmd.idx_init = IDX_ZERO;
					endcase
				end
			end
			ST_RUN: begin
				if (st.out_free) begin
					case (op_q)
						OP_WATCH: begin
							// downward search for the highest free slot
							if (!st.cur_valid) begin
								cmd.claim    = 1'b1;
								cmd.emit     = 1'b1;
								cmd.ok       = 1'b1;
								cmd.slot_sel = SSEL_IDX;
								cmd.task_sel = TSEL_ITEM;
								cmd.last     = 1'b1;
								state_d      = ST_IDLE;
							end else if (st.at_zero) begin
								cmd.emit     = 1'b1;
								cmd.task_sel = TSEL_ITEM;
								cmd.last     = 1'b1;
								state_d      = ST_IDLE;
							end else begin
								cmd.step_down = 1'b1;
							end
						end
						OP_LOOKUP, OP_RESTART: begin
							// upward search for the task
							if (st.cur_valid && st.task_match) begin
								cmd.restart  = (op_q == OP_RESTART);
								cmd.emit     = 1'b1;
								cmd.ok       = 1'b1;
								cmd.slot_sel = SSEL_IDX;
								cmd.task_sel = TSEL_ITEM;
								cmd.last     = 1'b1;
								state_d      = ST_IDLE;
							end else if (st.at_top) begin
								cmd.emit     = 1'b1;
								cmd.task_sel = TSEL_ITEM;
								cmd.last     = 1'b1;
								state_d      = ST_IDLE;
							end else begin
								cmd.step_up = 1'b1;
							end
						end
						OP_REMOVE: begin
							cmd.emit     = 1'b1;
							cmd.slot_sel = SSEL_ITEM;
							cmd.last     = 1'b1;
							state_d      = ST_IDLE;
							if (st.rm_in_range && st.cur_valid) begin
								cmd.free     = 1'b1;
								cmd.ok       = 1'b1;
								cmd.task_sel = TSEL_SLOT;
							end
						end
						OP_SCAN, OP_SCAN_FIRST: begin
							// one slot per cycle unless stalled; summary after a full walk
							if (st.cur_valid && st.done_bit) begin
								cmd.free = 1'b1;
							end else if (st.cur_valid && st.overdue) begin
								cmd.emit     = 1'b1;
								cmd.kind     = KIND_VIOL;
								cmd.slot_sel = SSEL_IDX;
								cmd.task_sel = TSEL_SLOT;
								if (op_q == OP_SCAN_FIRST) begin
									cmd.last = 1'b1;
								end else begin
									cmd.free = 1'b1;
									clean_d  = 1'b0;
								end
							end
							if (op_q == OP_SCAN_FIRST && st.cur_valid && !st.done_bit
									&& st.overdue) begin
								state_d = ST_IDLE;
							end else if (st.at_top) begin
								state_d = ST_SUM;
							end else begin
								cmd.step_up = 1'b1;
							end
						end
						OP_CLEAR: begin
							cmd.clear_all = 1'b1;
							cmd.emit      = 1'b1;
							cmd.ok        = 1'b1;
							cmd.last      = 1'b1;
							state_d       = ST_IDLE;
						end
						default: begin
							cmd.emit = 1'b1;
							cmd.last = 1'b1;
							state_d  = ST_IDLE;
						end
					endcase
				end
			end
			ST_SUM: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = KIND_SUMMARY;
					cmd.ok   = clean_q;
					cmd.last = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/dwt_datapath.sv =====
// datapath of the deadline watch table: slot store, live count, walk index,
// elapsed time check and result register; depends on dwt_pkg
`timescale 1ns / 1ps

module dwt_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dwt_pkg::dwt_cmd_t           cmd,
	output dwt_pkg::dwt_status_t        st,
	input  logic [dwt_pkg::TASK_W-1:0]  in_task_id,
	input  logic [dwt_pkg::LIMIT_W-1:0] in_limit,
	input  logic [dwt_pkg::SIDX_W-1:0]  in_slot_index,
	input  logic [dwt_pkg::NOW_W-1:0]   in_now,
	input  logic [dwt_pkg::MASK_W-1:0]  in_done_mask,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic [dwt_pkg::KIND_W-1:0]  out_kind,
	output logic                        out_ok,
	output logic [dwt_pkg::SIDX_W-1:0]  out_slot_index,
	output logic [dwt_pkg::TASK_W-1:0]  out_task_id,
	output logic [dwt_pkg::LCNT_W-1:0]  out_live_count,
	output logic                        out_last
);
	import dwt_pkg::*;

	// operands of the current item
	logic [TASK_ID_BITS-1:0] task_q;
	logic [TIME_BITS-1:0]    limit_q;
	logic [SIDX_W-1:0]       sidx_q;
	logic [TIME_BITS-1:0]    now_q;
	logic [SLOTS-1:0]        done_q;

	// slot store
	logic [SLOTS-1:0]        valid_q;
	logic [TASK_ID_BITS-1:0] task_mem  [SLOTS];
	logic [TIME_BITS-1:0]    limit_mem [SLOTS];
	logic [TIME_BITS-1:0]    start_mem [SLOTS];

	logic [IDX_W-1:0]        idx_q;
	logic [CNT_W-1:0]        cnt_q, cnt_next;

	logic [TASK_ID_BITS-1:0] cur_task;
	logic [TIME_BITS-1:0]    elapsed;

	logic                    out_valid_q;
	logic [KIND_W-1:0]       kind_q;
	logic                    ok_q;
	logic [SIDX_W-1:0]       slot_out_q;
	logic [TASK_W-1:0]       task_out_q;
	logic [LCNT_W-1:0]       lcnt_out_q;
	logic                    last_q;

	// operand capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			task_q  <= TASK_ID_BITS'(in_task_id);
			limit_q <= TIME_BITS'(in_limit);
			sidx_q  <= in_slot_index;
			now_q   <= TIME_BITS'(in_now);
			done_q  <= SLOTS'(in_done_mask);
		end
	end

	// walk index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.load) begin
			case (cmd.idx_init)
				IDX_TOP:  idx_q <= IDX_W'(SLOTS - 1);
				IDX_ITEM: idx_q <= IDX_W'(in_slot_index);
				default:  idx_q <= '0;
			endcase
		end else if (cmd.step_up) begin
			idx_q <= idx_q + 1'b1;
		end else if (cmd.step_down) begin
			idx_q <= idx_q - 1'b1;
		end
	end

	// slot read at the walk index and elapsed time check
	assign cur_task = task_mem[idx_q];
	assign elapsed  = now_q - start_mem[idx_q];

	assign st.out_free    = !out_valid_q || out_ready;
	assign st.cur_valid   = valid_q[idx_q];
	assign st.task_match  = (cur_task == task_q);
	assign st.done_bit    = done_q[idx_q];
	assign st.overdue     = (elapsed > limit_mem[idx_q]);
	assign st.at_top      = (idx_q == IDX_W'(SLOTS - 1));
	assign st.at_zero     = (idx_q == '0);
	assign st.rm_in_range = ({1'b0, sidx_q} < (SIDX_W + 1)'(SLOTS));

	// valid marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.clear_all) begin
			valid_q <= '0;
		end else if (cmd.claim) begin
			valid_q[idx_q] <= 1'b1;
		end else if (cmd.free) begin
			valid_q[idx_q] <= 1'b0;
		end
	end

	// slot contents
	always_ff @(posedge clk) begin
		if (cmd.claim) begin
			task_mem[idx_q]  <= task_q;
			limit_mem[idx_q] <= limit_q;
		end
		if (cmd.claim || cmd.restart) begin
			start_mem[idx_q] <= now_q;
		end
	end

	// live count
	always_comb begin
		cnt_next = cnt_q;
		if (cmd.clear_all) begin
			cnt_next = '0;
		end else if (cmd.claim) begin
			cnt_next = cnt_q + 1'b1;
		end else if (cmd.free && cnt_q != '0) begin
			cnt_next = cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind_q     <= cmd.kind;
			ok_q       <= cmd.ok;
			last_q     <= cmd.last;
			lcnt_out_q <= LCNT_W'(cnt_next);
			case (cmd.slot_sel)
				SSEL_IDX:  slot_out_q <= SIDX_W'(idx_q);
				SSEL_ITEM: slot_out_q <= sidx_q;
				default:   slot_out_q <= '0;
			endcase
			case (cmd.task_sel)
				TSEL_ITEM: task_out_q <= TASK_W'(task_q);
				TSEL_SLOT: task_out_q <= TASK_W'(cur_task);
				default:   task_out_q <= '0;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign out_kind       = kind_q;
	assign out_ok         = ok_q;
	assign out_slot_index = slot_out_q;
	assign out_task_id    = task_out_q;
	assign out_live_count = lcnt_out_q;
	assign out_last       = last_q;

endmodule

// ===== hw/rtl/dwt_checker.sv =====
// port-level checks of the deadline watch table result channel, bound to the top
// depends on dwt_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dwt_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [dwt_pkg::KIND_W-1:0]  kind,
	input logic                        ok,
	input logic [dwt_pkg::SIDX_W-1:0]  slot_index_out,
	input logic [dwt_pkg::TASK_W-1:0]  task_id_out,
	input logic [dwt_pkg::LCNT_W-1:0]  live_count_out,
	input logic                        last
);
	import dwt_pkg::*;

	logic [KIND_W+SIDX_W+TASK_W+LCNT_W+1:0] payload;
	logic                                   no_slot_task;

	// whole result payload and the empty slot and task of a summary
	assign payload      = {kind, ok, slot_index_out, task_id_out, live_count_out, last};
	assign no_slot_task = (slot_index_out == '0) && (task_id_out == '0);

	// a stalled result holds
	`DWT_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(payload))

	// count never exceeds the table size
	`DWT_ASSERT_IMP(a_count_range, clk, arst_n, out_valid, live_count_out <= LCNT_W'(SLOTS))

	// only violation reports of a full scan may be followed by more results
	`DWT_ASSERT_IMP(a_last_kind, clk, arst_n, out_valid && kind != KIND_VIOL, last)

	// a violation report never claims success
	`DWT_ASSERT_IMP(a_viol_fail, clk, arst_n, out_valid && kind == KIND_VIOL, !ok)

	// a scan summary names no slot and no task
	`DWT_ASSERT_IMP(a_summary_zero, clk, arst_n, out_valid && kind == KIND_SUMMARY, no_slot_task)

endmodule

bind deadline_watch_table_unit dwt_checker u_dwt_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (result.valid),
	.out_ready      (result.ready),
	.kind           (result.kind),
	.ok             (result.ok),
	.slot_index_out (result.slot_index_out),
	.task_id_out    (result.task_id_out),
	.live_count_out (result.live_count_out),
	.last           (result.last)
);
